/* design/dcgw_pkg.sv */
// ----------------------------------------------------------------------------
// dcgw_pkg
// Shared types and constants of the descriptor chain gather walker: request
// status codes, configuration register map and the structs passed between
// the configuration block, the walk core and the top level.
// ----------------------------------------------------------------------------
package dcgw_pkg;

    // Request status as reported with every result
    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_OK      = 2'd1,
        ST_SHORT   = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    // Configuration map: register i sits at byte address 8*i
    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 64;
    localparam logic [1:0]  REG_START_OFFSET = 2'd0;
    localparam logic [1:0]  REG_COPY_BYTES   = 2'd1;
    localparam logic [1:0]  REG_RAM_BYTES    = 2'd2;

    localparam logic [32:0] RAM_BYTES_RESET = 33'h0_2000_0000;

    // Configuration register contents
    typedef struct packed {
        logic [31:0] start_offset;
        logic [31:0] copy_bytes;
        logic [32:0] ram_bytes;
    } t_cfg;

    // One descriptor from the fetch stream
    typedef struct packed {
        logic [63:0] desc_addr;
        logic [31:0] desc_len;
        logic        desc_writable;
        logic        chain_last;
    } t_desc;

    // One copy command / status result
    typedef struct packed {
        logic        chunk_valid;
        logic [31:0] copy_addr;
        logic [31:0] copy_len;
        logic [31:0] buffer_offset;
        t_status     status;
        logic        request_done;
    } t_result;

endpackage

/* design/dcgw_cfg_regs.sv */
// ----------------------------------------------------------------------------
// dcgw_cfg_regs
// APB-style configuration registers: start offset, copy byte count and guest
// RAM size. Zero-wait writes, combinational read data.
// ----------------------------------------------------------------------------
module dcgw_cfg_regs
    import dcgw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign w_wr  = psel && penable && pwrite;
    assign w_idx = paddr[CFG_ADDR_W-1:3];

    // Write the addressed register in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_offset <= '0;
            r_cfg.copy_bytes   <= '0;
            r_cfg.ram_bytes    <= RAM_BYTES_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_START_OFFSET: r_cfg.start_offset <= pwdata[31:0];
                REG_COPY_BYTES:   r_cfg.copy_bytes   <= pwdata[31:0];
                REG_RAM_BYTES:    r_cfg.ram_bytes    <= pwdata[32:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (w_idx)
            REG_START_OFFSET: prdata = {32'd0, r_cfg.start_offset};
            REG_COPY_BYTES:   prdata = {32'd0, r_cfg.copy_bytes};
            REG_RAM_BYTES:    prdata = {31'd0, r_cfg.ram_bytes};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* design/dcgw_walk_core.sv */
// ----------------------------------------------------------------------------
// dcgw_walk_core
// Chain walk state and the per-descriptor step: skip, bounds check, chunk
// sizing and request completion. State advances when i_step is high.
// ----------------------------------------------------------------------------
module dcgw_walk_core
    import dcgw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_step,
    input  t_desc   i_desc,
    output t_result o_result
);

    logic        r_in_chain;
    logic        r_finished;
    t_status     r_final_status;
    logic [31:0] r_skip_left;
    logic [31:0] r_gathered;

    logic        n_in_chain;
    logic        n_finished;
    t_status     n_final_status;
    logic [31:0] n_skip_left;
    logic [31:0] n_gathered;

    // Hold chain state between descriptors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_chain     <= 1'b0;
            r_finished     <= 1'b0;
            r_final_status <= ST_BUSY;
            r_skip_left    <= '0;
            r_gathered     <= '0;
        end else if (i_step) begin
            r_in_chain     <= n_in_chain;
            r_finished     <= n_finished;
            r_final_status <= n_final_status;
            r_skip_left    <= n_skip_left;
            r_gathered     <= n_gathered;
        end
    end

    // Process one descriptor
    always_comb begin
        logic        first;
        logic [31:0] skip;
        logic [31:0] gath;
        logic        fin;
        t_status     fstat;
        logic [32:0] start_sum;
        logic [31:0] caddr;
        logic [31:0] avail;
        logic [31:0] remaining;
        logic [31:0] clen;
        logic [33:0] end_sum;
        logic [31:0] gath_new;
        logic        bad_addr;
        logic        bad_ram;

        first     = !r_in_chain;
        skip      = first ? i_cfg.start_offset : r_skip_left;
        gath      = first ? 32'd0 : r_gathered;
        fin       = first ? 1'b0 : r_finished;
        fstat     = first ? ST_BUSY : r_final_status;
        start_sum = {1'b0, i_desc.desc_addr[31:0]} + {1'b0, skip};
        caddr     = start_sum[31:0];
        avail     = i_desc.desc_len - skip;
        remaining = i_cfg.copy_bytes - gath;
        clen      = (remaining < avail) ? remaining : avail;
        end_sum   = {2'b00, caddr} + {2'b00, clen};
        gath_new  = gath + clen;
        bad_addr  = (i_desc.desc_addr[63:32] != 32'd0) || start_sum[32];
        bad_ram   = ({1'b0, caddr} >= i_cfg.ram_bytes) ||
                    (end_sum > {1'b0, i_cfg.ram_bytes});

        n_in_chain     = 1'b1;
        n_finished     = fin;
        n_final_status = fstat;
        n_skip_left    = skip;
        n_gathered     = gath;

        o_result.chunk_valid   = 1'b0;
        o_result.copy_addr     = '0;
        o_result.copy_len      = '0;
        o_result.buffer_offset = '0;
        o_result.status        = ST_BUSY;
        o_result.request_done  = 1'b0;

        if (first && (i_cfg.copy_bytes == 32'd0)) begin
            // Nothing to gather: finish ok at once
            o_result.status       = ST_OK;
            o_result.request_done = 1'b1;
            n_final_status        = ST_OK;
            n_finished            = !i_desc.chain_last;
            n_in_chain            = !i_desc.chain_last;
        end else if (fin) begin
            // Drain the rest of a finished chain
            o_result.status = fstat;
            if (i_desc.chain_last) begin
                n_in_chain = 1'b0;
                n_finished = 1'b0;
            end
        end else if (i_desc.desc_writable) begin
            o_result.status       = ST_SHORT;
            o_result.request_done = 1'b1;
            n_final_status        = ST_SHORT;
            n_finished            = !i_desc.chain_last;
            n_in_chain            = !i_desc.chain_last;
        end else if (skip >= i_desc.desc_len) begin
            // Whole descriptor consumed by the skip
            n_skip_left = skip - i_desc.desc_len;
            if (i_desc.chain_last) begin
                o_result.status       = ST_SHORT;
                o_result.request_done = 1'b1;
                n_final_status        = ST_SHORT;
                n_in_chain            = 1'b0;
                n_finished            = 1'b0;
            end
        end else if (bad_addr || bad_ram) begin
            o_result.status       = ST_INVALID;
            o_result.request_done = 1'b1;
            n_final_status        = ST_INVALID;
            n_finished            = !i_desc.chain_last;
            n_in_chain            = !i_desc.chain_last;
        end else begin
            // Issue a copy chunk
            o_result.chunk_valid   = 1'b1;
            o_result.copy_addr     = caddr;
            o_result.copy_len      = clen;
            o_result.buffer_offset = gath;
            n_gathered             = gath_new;
            n_skip_left            = '0;
            if (gath_new == i_cfg.copy_bytes) begin
                o_result.status       = ST_OK;
                o_result.request_done = 1'b1;
                n_final_status        = ST_OK;
                n_finished            = !i_desc.chain_last;
                n_in_chain            = !i_desc.chain_last;
            end else if (i_desc.chain_last) begin
                o_result.status       = ST_SHORT;
                o_result.request_done = 1'b1;
                n_final_status        = ST_SHORT;
                n_in_chain            = 1'b0;
                n_finished            = 1'b0;
            end
        end
    end

endmodule

/* design/descriptor_chain_gather_walker.sv */
// ----------------------------------------------------------------------------
// descriptor_chain_gather_walker
// Pipeline: input register, then result register, with the walk core
//   sitting between the two.
// Throughput: one descriptor per cycle while the copy command stream does
//   not stall; the chain state update in the walk core completes within that cycle.
// Reset: synchronous active-low; clears both stages, chain state and loads
//   register defaults (RAM size 0x2000_0000).
// ----------------------------------------------------------------------------
module descriptor_chain_gather_walker
    import dcgw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Descriptor stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [95:0]           i_s_axis_tdata,  // [63:0] desc_addr, [95:64] desc_len
    input  logic                  i_s_axis_tuser,  // [0] desc_writable
    input  logic                  i_s_axis_tlast,  // chain_last
    // Copy command stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [95:0]           o_m_axis_tdata,  // [31:0] copy_addr, [63:32] copy_len,
                                                   // [95:64] buffer_offset
    output logic [2:0]            o_m_axis_tuser,  // [0] chunk_valid, [2:1] status
    output logic                  o_m_axis_tlast,  // request_done
    // Configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg    w_cfg;
    t_desc   r_in;
    logic    r_in_valid;
    t_result w_result;
    t_result r_out;
    logic    r_out_valid;
    logic    w_adv;

    assign pready = 1'b1;

    dcgw_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    // Advance the input stage whenever the result slot is free or drains
    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.desc_addr     <= i_s_axis_tdata[63:0];
            r_in.desc_len      <= i_s_axis_tdata[95:64];
            r_in.desc_writable <= i_s_axis_tuser;
            r_in.chain_last    <= i_s_axis_tlast;
        end
    end

    dcgw_walk_core u_walk_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_step   (w_adv),
        .i_desc   (r_in),
        .o_result (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.buffer_offset, r_out.copy_len, r_out.copy_addr};
    assign o_m_axis_tuser  = {r_out.status, r_out.chunk_valid};
    assign o_m_axis_tlast  = r_out.request_done;

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the descriptor chain gather walker. Descriptors are sent on the
// input stream and every copy command is compared, field by field, with a
// cycle-free predictor of the chain walk or, for fixed rows, a typed-in result.
// A short directed table covers the corner cases, then random chains run under
// random register settings. Random gaps and stalls are applied on both stream sides.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dcgw_pkg::*;

    // One row of the directed table: a register write or a descriptor
    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_idx;
        logic [63:0] value;
        t_desc       desc;
        bit          has_fixed;
        t_result     fixed;
    } t_step;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [95:0] s_tdata  = '0;   // [63:0] desc_addr, [95:64] desc_len
    logic        s_tuser  = 1'b0; // [0] desc_writable
    logic        s_tlast  = 1'b0; // chain_last

    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire [95:0]  m_tdata;         // [31:0] copy_addr, [63:32] copy_len,
                                  // [95:64] buffer_offset
    wire [2:0]   m_tuser;         // [0] chunk_valid, [2:1] status
    wire         m_tlast;         // request_done

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    wire  [CFG_DATA_W-1:0] prdata;
    wire                   pready;

    // Register copies used by the predictor
    logic [31:0] cfg_start_offset = '0;
    logic [31:0] cfg_copy_bytes   = '0;
    logic [32:0] cfg_ram_bytes    = RAM_BYTES_RESET;

    // Chain walk state of the predictor
    logic [31:0] bytes_to_skip  = '0;
    logic [31:0] bytes_gathered = '0;
    logic        request_closed = 1'b0;
    logic        chain_open     = 1'b0;
    t_status     closing_status = ST_BUSY;

    t_result expected_chunks[$];
    t_step   directed_plan[$];

    bit src_calm = 1'b0;
    bit snk_calm = 1'b0;

    int mismatches       = 0;
    int descriptors_sent = 0;
    int results_seen     = 0;
    int chunks_seen      = 0;
    int register_writes  = 0;
    int closed_with[4]   = '{default: 0};

    descriptor_chain_gather_walker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Free-running clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop if the run hangs
    initial begin
        #2_000_000;
        $display("[descriptor_chain_gather_walker] ERROR");
        $finish;
    end

    // End the current request; on chain_last the next descriptor opens a chain
    function automatic void close_request(input t_status st, input logic last);
        closing_status = st;
        request_closed = !last;
        if (last) begin
            chain_open = 1'b0;
        end
    endfunction

    // Advance the chain walk by one descriptor and return its copy command
    function automatic t_result walk_descriptor(input t_desc d);
        t_result     r;
        logic [64:0] chunk_start;
        logic [31:0] avail;
        logic [31:0] remaining;
        logic [31:0] clen;
        logic [31:0] boff;
        r = '0;
        r.status = ST_BUSY;
        if (!chain_open) begin
            chain_open     = 1'b1;
            request_closed = 1'b0;
            closing_status = ST_BUSY;
            bytes_to_skip  = cfg_start_offset;
            bytes_gathered = '0;
            if (cfg_copy_bytes == 0) begin
                close_request(ST_OK, d.chain_last);
                r.status       = ST_OK;
                r.request_done = 1'b1;
                return r;
            end
        end else if (request_closed) begin
            if (d.chain_last) begin
                chain_open     = 1'b0;
                request_closed = 1'b0;
            end
            r.status = closing_status;
            return r;
        end

        // writable descriptor ends the readable part
        if (d.desc_writable) begin
            close_request(ST_SHORT, d.chain_last);
            r.status       = ST_SHORT;
            r.request_done = 1'b1;
            return r;
        end

        // consume whole descriptor by the skip
        if (bytes_to_skip >= d.desc_len) begin
            bytes_to_skip = bytes_to_skip - d.desc_len;
            if (d.chain_last) begin
                close_request(ST_SHORT, 1'b1);
                r.status       = ST_SHORT;
                r.request_done = 1'b1;
            end
            return r;
        end

        chunk_start = {1'b0, d.desc_addr} + {33'd0, bytes_to_skip};
        if (d.desc_addr > 64'hFFFF_FFFF || chunk_start > 65'hFFFF_FFFF) begin
            close_request(ST_INVALID, d.chain_last);
            r.status       = ST_INVALID;
            r.request_done = 1'b1;
            return r;
        end
        avail     = d.desc_len - bytes_to_skip;
        remaining = cfg_copy_bytes - bytes_gathered;
        clen      = (remaining < avail) ? remaining : avail;

        // bounds check against guest RAM
        if (chunk_start >= {32'd0, cfg_ram_bytes} || {1'b0, clen} > cfg_ram_bytes ||
            chunk_start + {33'd0, clen} > {32'd0, cfg_ram_bytes}) begin
            close_request(ST_INVALID, d.chain_last);
            r.status       = ST_INVALID;
            r.request_done = 1'b1;
            return r;
        end

        boff           = bytes_gathered;
        bytes_gathered = bytes_gathered + clen;
        bytes_to_skip  = '0;
        r.chunk_valid   = 1'b1;
        r.copy_addr     = chunk_start[31:0];
        r.copy_len      = clen;
        r.buffer_offset = boff;
        if (bytes_gathered == cfg_copy_bytes) begin
            close_request(ST_OK, d.chain_last);
            r.status       = ST_OK;
            r.request_done = 1'b1;
        end else if (d.chain_last) begin
            close_request(ST_SHORT, 1'b1);
            r.status       = ST_SHORT;
            r.request_done = 1'b1;
        end
        return r;
    endfunction

    // Table builders
    function automatic void add_cfg(input logic [1:0] idx, input logic [63:0] value);
        t_step s;
        s = '{default: '0};
        s.is_cfg  = 1'b1;
        s.reg_idx = idx;
        s.value   = value;
        directed_plan.push_back(s);
    endfunction

    function automatic void add_desc(input logic [63:0] addr, input logic [31:0] len,
                                     input logic writable, input logic last);
        t_step s;
        s = '{default: '0};
        s.desc = '{desc_addr: addr, desc_len: len, desc_writable: writable,
                   chain_last: last};
        directed_plan.push_back(s);
    endfunction

    // Row whose result carries no chunk and is typed in directly
    function automatic void add_fixed(input logic [63:0] addr, input logic [31:0] len,
                                      input logic writable, input logic last,
                                      input t_status st, input logic done);
        t_step s;
        s = '{default: '0};
        s.desc = '{desc_addr: addr, desc_len: len, desc_writable: writable,
                   chain_last: last};
        s.has_fixed          = 1'b1;
        s.fixed              = '0;
        s.fixed.status       = st;
        s.fixed.request_done = done;
        directed_plan.push_back(s);
    endfunction

    // Drop valid and wait until every copy command has come back
    task automatic wait_idle();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (expected_chunks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write one register through the APB port
    task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_START_OFFSET: cfg_start_offset = value[31:0];
            REG_COPY_BYTES:   cfg_copy_bytes   = value[31:0];
            REG_RAM_BYTES:    cfg_ram_bytes    = value[32:0];
            default: ;
        endcase
        register_writes++;
    endtask

    // Send one descriptor request after a random gap and log its expectation
    task automatic send_descriptor(input t_desc d, input bit has_fixed,
                                   input t_result fixed);
        int      gap;
        t_result predicted;
        gap = src_calm ? 0 : $urandom_range(0, 17);
        repeat (gap) begin
            @(negedge i_clk);
            s_tvalid = 1'b0;
        end
        @(negedge i_clk);
        s_tvalid = 1'b1;
        s_tdata  = {d.desc_len, d.desc_addr};
        s_tuser  = d.desc_writable;
        s_tlast  = d.chain_last;
        do @(posedge i_clk); while (!s_tready);
        predicted = walk_descriptor(d);
        expected_chunks.push_back(has_fixed ? fixed : predicted);
        descriptors_sent++;
    endtask

    // Copy command side: random stalls, compare against the oldest expectation
    initial begin : chunk_sink
        int      stall;
        t_result got;
        t_result want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = snk_calm ? 0 : $urandom_range(0, 17);
            repeat (stall) begin
                @(negedge i_clk);
                m_tready = 1'b0;
            end
            @(negedge i_clk);
            m_tready = 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            got.chunk_valid   = m_tuser[0];
            got.status        = t_status'(m_tuser[2:1]);
            got.copy_addr     = m_tdata[31:0];
            got.copy_len      = m_tdata[63:32];
            got.buffer_offset = m_tdata[95:64];
            got.request_done  = m_tlast;
            results_seen++;
            if (got.chunk_valid === 1'b1) chunks_seen++;
            if (got.request_done === 1'b1 && !$isunknown(got.status)) begin
                closed_with[int'(got.status)]++;
            end
            if (expected_chunks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected copy command: valid=%0d addr=%h len=%h off=%h st=%0d done=%0d",
                             got.chunk_valid, got.copy_addr, got.copy_len,
                             got.buffer_offset, got.status, got.request_done);
                end
            end else begin
                want = expected_chunks.pop_front();
                if (got.chunk_valid !== want.chunk_valid || got.copy_addr !== want.copy_addr ||
                    got.copy_len !== want.copy_len ||
                    got.buffer_offset !== want.buffer_offset ||
                    got.status !== want.status || got.request_done !== want.request_done) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d: expected valid=%0d addr=%h len=%h off=%h st=%0d done=%0d",
                                 results_seen, want.chunk_valid, want.copy_addr, want.copy_len,
                                 want.buffer_offset, want.status, want.request_done);
                        $display("result %0d:   actual valid=%0d addr=%h len=%h off=%h st=%0d done=%0d",
                                 results_seen, got.chunk_valid, got.copy_addr, got.copy_len,
                                 got.buffer_offset, got.status, got.request_done);
                    end
                end
            end
        end
    end

    // Stimulus: reset, directed table, random chains, drain and verdict
    initial begin : stimulus
        t_desc       d;
        int          random_sent;
        int          phase_end;
        int          chain_len;
        int          roll;
        logic [63:0] span;
        logic [31:0] new_start;
        logic [31:0] new_copy;
        logic [32:0] new_ram;

        // zero copy count finishes on the first descriptor, whatever it holds
        add_fixed(64'h0, 32'h0, 1'b0, 1'b1, ST_OK, 1'b1);
        add_fixed(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_OK, 1'b1);
        add_fixed(64'h40, 32'h10, 1'b0, 1'b1, ST_OK, 1'b0);
        // plain gather, tail of a finished chain, writable, address checks
        add_cfg(REG_COPY_BYTES, 64'd16);
        add_desc(64'h1000, 32'd8, 1'b0, 1'b0);
        add_desc(64'h2000, 32'd100, 1'b0, 1'b0);
        add_fixed(64'h3000, 32'd4, 1'b0, 1'b1, ST_OK, 1'b0);
        add_fixed(64'h3000, 32'd4, 1'b1, 1'b1, ST_SHORT, 1'b1);
        add_fixed(64'h1_0000_0000, 32'd4, 1'b0, 1'b1, ST_INVALID, 1'b1);
        add_fixed(64'h1FFF_FFFC, 32'd8, 1'b0, 1'b1, ST_INVALID, 1'b1);
        add_fixed(64'h2000_0000, 32'd1, 1'b0, 1'b1, ST_INVALID, 1'b1);
        add_desc(64'h100, 32'd4, 1'b0, 1'b1);
        // skip across whole descriptors, skip reaching chain end, skip overflow
        add_cfg(REG_START_OFFSET, 64'd10);
        add_fixed(64'h500, 32'd6, 1'b0, 1'b0, ST_BUSY, 1'b0);
        add_fixed(64'h600, 32'd4, 1'b0, 1'b0, ST_BUSY, 1'b0);
        add_desc(64'h700, 32'd20, 1'b0, 1'b0);
        add_fixed(64'h800, 32'd20, 1'b0, 1'b1, ST_OK, 1'b0);
        add_fixed(64'h500, 32'd2, 1'b0, 1'b1, ST_SHORT, 1'b1);
        add_fixed(64'hFFFF_FFFA, 32'd20, 1'b0, 1'b1, ST_INVALID, 1'b1);
        // largest RAM and copy count
        add_cfg(REG_RAM_BYTES, 64'h1_0000_0000);
        add_cfg(REG_START_OFFSET, 64'd0);
        add_cfg(REG_COPY_BYTES, 64'hFFFF_FFFF);
        add_fixed(64'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, ST_INVALID, 1'b1);
        add_fixed(64'h0, 32'h0, 1'b0, 1'b1, ST_INVALID, 1'b0);
        add_desc(64'h0, 32'hFFFF_FFFF, 1'b0, 1'b1);
        // empty and single-byte RAM, largest skip
        add_cfg(REG_RAM_BYTES, 64'd0);
        add_cfg(REG_COPY_BYTES, 64'd1);
        add_fixed(64'h0, 32'd1, 1'b0, 1'b1, ST_INVALID, 1'b1);
        add_cfg(REG_RAM_BYTES, 64'd1);
        add_desc(64'h0, 32'd1, 1'b0, 1'b1);
        add_cfg(REG_START_OFFSET, 64'hFFFF_FFFF);
        add_fixed(64'h0, 32'hFFFF_FFFF, 1'b0, 1'b1, ST_SHORT, 1'b1);

        // hold reset, then release it at a falling clock edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_cfg) begin
                wait_idle();
                write_register(directed_plan[i].reg_idx, directed_plan[i].value);
            end else begin
                send_descriptor(directed_plan[i].desc, directed_plan[i].has_fixed,
                                directed_plan[i].fixed);
            end
        end

        // random phases, each under fresh register settings
        random_sent = 0;
        while (random_sent < 950) begin
            wait_idle();
            roll = $urandom_range(0, 19);
            if (roll < 10)      new_start = 32'd0;
            else if (roll < 16) new_start = $urandom_range(1, 96);
            else if (roll < 19) new_start = $urandom;
            else                new_start = 32'hFFFF_FFFF;
            roll = $urandom_range(0, 19);
            if (roll < 2)       new_copy = 32'd0;
            else if (roll < 13) new_copy = $urandom_range(1, 256);
            else if (roll < 17) new_copy = $urandom_range(257, 65536);
            else if (roll < 19) new_copy = $urandom;
            else                new_copy = 32'hFFFF_FFFF;
            roll = $urandom_range(0, 19);
            if (roll < 8)       new_ram = RAM_BYTES_RESET;
            else if (roll < 12) new_ram = 33'h1_0000_0000;
            else if (roll < 16) new_ram = 33'($urandom_range(1, 4096));
            else if (roll < 19) new_ram = {1'($urandom_range(0, 1)), 32'($urandom)};
            else                new_ram = 33'd0;
            write_register(REG_START_OFFSET, {32'd0, new_start});
            write_register(REG_COPY_BYTES, {32'd0, new_copy});
            write_register(REG_RAM_BYTES, {31'd0, new_ram});
            src_calm = ($urandom_range(0, 3) == 0);
            snk_calm = ($urandom_range(0, 3) == 0);

            // keep addresses mostly inside guest RAM
            if (cfg_ram_bytes == 0)                  span = 64'd1;
            else if (cfg_ram_bytes > 33'hFFFF_FFFF)  span = 64'h1_0000_0000;
            else                                     span = 64'(cfg_ram_bytes);

            phase_end = random_sent + $urandom_range(40, 90);
            while (random_sent < phase_end) begin
                chain_len = $urandom_range(1, 6);
                for (int k = 0; k < chain_len; k++) begin
                    roll = $urandom_range(0, 99);
                    d.desc_addr     = 64'($urandom) % span;
                    d.desc_writable = ($urandom_range(0, 14) == 0);
                    d.chain_last    = (k == chain_len - 1);
                    case ($urandom_range(0, 9))
                        0, 1:    d.desc_len = $urandom_range(0, 4096);
                        2:       d.desc_len = $urandom;
                        default: d.desc_len = $urandom_range(0, 64);
                    endcase
                    if (roll < 8) begin
                        // pure noise
                        d.desc_addr     = {32'($urandom), 32'($urandom)};
                        d.desc_len      = $urandom;
                        d.desc_writable = 1'($urandom_range(0, 1));
                        d.chain_last    = 1'($urandom_range(0, 1));
                    end else if (roll < 12) begin
                        // broken chain framing
                        d.chain_last = ~d.chain_last;
                    end else if (roll < 22) begin
                        // land near the end of RAM
                        d.desc_addr = span - 64'($urandom_range(1, 64));
                    end
                    send_descriptor(d, 1'b0, '0);
                    random_sent++;
                end
            end
        end

        // drain and let the pipeline settle
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (expected_chunks.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("sent %0d descriptors, got %0d copy commands (%0d chunks), %0d register writes",
                 descriptors_sent, results_seen, chunks_seen, register_writes);
        $display("requests closed ok %0d, short %0d, invalid %0d; %0d mismatches",
                 closed_with[int'(ST_OK)], closed_with[int'(ST_SHORT)],
                 closed_with[int'(ST_INVALID)], mismatches);
        if (mismatches == 0) begin
            $display("[descriptor_chain_gather_walker] OK");
        end else begin
            $display("[descriptor_chain_gather_walker] ERROR");
        end
        $finish;
    end

endmodule
